// ===== hdl/bdac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdac_pkg;

   // default sizes, handed to the top level parameters
   localparam int DEF_MAX_SRC_DIM   = 4096;
   localparam int DEF_MAX_THUMB_DIM = 256;
   localparam int DEF_CHECKER_CELL  = 10;

   // configuration port
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_DIM    = 2'd2;

   localparam logic [12:0] RST_SRC_WIDTH  = 13'd256;
   localparam logic [12:0] RST_SRC_HEIGHT = 13'd256;
   localparam logic [8:0]  RST_MAX_DIM    = 9'd128;

   // checkerboard shades
   localparam logic [7:0] BG_LIGHT = 8'd60;
   localparam logic [7:0] BG_DARK  = 8'd42;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pix_type;

   // per-beat classification made by the front
   typedef struct packed {
      logic first;   // first touch of this column entry in the box row
      logic emit;    // bottom-right pixel of a box
      logic last;    // final thumbnail pixel of the frame
      logic odd;     // light checker cell
   } ctl_type;

endpackage

`default_nettype wire

// ===== hdl/bdac_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module bdac_div
   import bdac_pkg::*;
#(
   parameter int NW = 22,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo,
   output logic [DW-1:0] rem
);

   localparam int CNTW = $clog2(NW + 1);

   logic [NW-1:0]   quo_ff;
   logic [DW-1:0]   rem_ff;
   logic [DW-1:0]   den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DW:0]     trial;
   logic            fits;

   // shift in the next numerator bit and test the divisor
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNTW'(1));
         if (start) begin
            quo_ff  <= num;
            rem_ff  <= '0;
            den_ff  <= den;
            cnt_ff  <= CNTW'(NW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[NW-2:0], fits};
            rem_ff <= fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ===== hdl/bdac_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// short queue between front and back
module bdac_fifo
   import bdac_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW:0]      count_ff;

   assign full  = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign dout  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PW+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bdac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// sizing sequencer and raster walker: classifies each pixel into its box
module bdac_front
   import bdac_pkg::*;
#(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_THUMB_DIM = DEF_MAX_THUMB_DIM,
   parameter int CHECKER_CELL  = DEF_CHECKER_CELL,
   localparam int SW  = $clog2(MAX_SRC_DIM + 1),
   localparam int TW  = $clog2(MAX_THUMB_DIM + 1),
   localparam int XW  = (MAX_THUMB_DIM > 1) ? $clog2(MAX_THUMB_DIM) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pix_type                req_pix,
   input  logic                   q_full,
   output logic                   q_push,
   output pix_type                q_pix,
   output ctl_type                q_ctl,
   output logic [XW-1:0]          q_x,
   output logic [7:0]             q_row,
   output logic [TW-1:0]          thumb_w,
   output logic [TW-1:0]          thumb_h
);

   localparam int DW  = (SW > TW) ? SW : TW;
   localparam int NW  = SW + TW;
   localparam int CCW = (CHECKER_CELL > 1) ? $clog2(CHECKER_CELL) : 1;
   localparam int EW  = SW + 1;

   typedef enum logic [2:0] {
      S_INIT,
      S_TW,
      S_TH,
      S_QW,
      S_QH,
      S_RUN
   } state_type;

   state_type state_ff;

   logic [12:0] reg_w_ff;
   logic [12:0] reg_h_ff;
   logic [8:0]  reg_m_ff;

   logic          start_ff;
   logic          start_in;
   logic          csr_hit;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic          div_done;
   logic [NW-1:0] div_quo;
   logic [DW-1:0] div_rem;
   logic          got;

   logic [TW-1:0] tw_ff, th_ff;
   logic [SW-1:0] qw_ff, qh_ff;
   logic [TW-1:0] rw_ff, rh_ff;

   logic [SW-1:0]  src_col_ff, src_row_ff;
   logic [XW-1:0]  dst_col_ff, dst_row_ff;
   logic [EW-1:0]  col_edge_ff, row_edge_ff;
   logic [TW-1:0]  col_rem_ff, row_rem_ff;
   logic           col_first_ff, row_first_ff;
   logic [CCW-1:0] col_cell_ff, row_cell_ff;
   logic           col_odd_ff, row_odd_ff;

   logic [SW-1:0] eff_w, eff_h, longest;
   logic [TW-1:0] eff_m;
   logic          fits_m;
   logic [TW-1:0] fit_side;

   logic          accept;
   logic [SW-1:0] src_col_in, src_row_in;
   logic          col_hit, row_hit, col_wrap, row_wrap;
   logic [TW:0]   col_sum, row_sum;
   logic          col_carry, row_carry;
   logic [EW-1:0] col_edge_in, row_edge_in;
   logic [TW-1:0] col_rem_in, row_rem_in;
   logic          col_cell_end, row_cell_end;

   bdac_div #(
      .NW (NW),
      .DW (DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // clamp the registers to their meaningful ranges
   always_comb begin
      if (reg_w_ff == '0) begin
         eff_w = SW'(1);
      end else if (32'(reg_w_ff) > 32'(MAX_SRC_DIM)) begin
         eff_w = SW'(MAX_SRC_DIM);
      end else begin
         eff_w = SW'(reg_w_ff);
      end
      if (reg_h_ff == '0) begin
         eff_h = SW'(1);
      end else if (32'(reg_h_ff) > 32'(MAX_SRC_DIM)) begin
         eff_h = SW'(MAX_SRC_DIM);
      end else begin
         eff_h = SW'(reg_h_ff);
      end
      if (reg_m_ff == '0) begin
         eff_m = TW'(1);
      end else if (32'(reg_m_ff) > 32'(MAX_THUMB_DIM)) begin
         eff_m = TW'(MAX_THUMB_DIM);
      end else begin
         eff_m = TW'(reg_m_ff);
      end
      longest = (eff_w > eff_h) ? eff_w : eff_h;
      fits_m  = 32'(longest) <= 32'(eff_m);
   end

   // scaled side, at least one
   assign fit_side = (div_quo == '0) ? TW'(1) : TW'(div_quo);
   assign got      = div_done && !start_ff;

   // divider kick: on entry to sizing and after each finished divide but the last
   assign csr_hit  = csr_write_en && (csr_index == REG_SRC_WIDTH ||
                     csr_index == REG_SRC_HEIGHT || csr_index == REG_MAX_DIM);
   assign start_in = !csr_hit && ((state_ff == S_INIT) ||
                     (got && (state_ff == S_TW || state_ff == S_TH || state_ff == S_QW)));

   // raster walk and box edges, advanced by quotient plus carried remainder
   assign accept     = req_valid && !req_stall;
   assign src_col_in = src_col_ff + SW'(1);
   assign src_row_in = src_row_ff + SW'(1);
   assign col_hit    = {1'b0, src_col_in} >= col_edge_ff;
   assign row_hit    = {1'b0, src_row_in} >= row_edge_ff;
   assign col_wrap   = src_col_in >= eff_w;
   assign row_wrap   = src_row_in >= eff_h;

   assign col_sum     = {1'b0, col_rem_ff} + {1'b0, rw_ff};
   assign col_carry   = col_sum >= {1'b0, tw_ff};
   assign col_edge_in = col_edge_ff + EW'(qw_ff) + EW'(col_carry);
   assign col_rem_in  = col_carry ? TW'(col_sum - {1'b0, tw_ff}) : TW'(col_sum);
   assign row_sum     = {1'b0, row_rem_ff} + {1'b0, rh_ff};
   assign row_carry   = row_sum >= {1'b0, th_ff};
   assign row_edge_in = row_edge_ff + EW'(qh_ff) + EW'(row_carry);
   assign row_rem_in  = row_carry ? TW'(row_sum - {1'b0, th_ff}) : TW'(row_sum);

   assign col_cell_end = col_cell_ff == CCW'(CHECKER_CELL - 1);
   assign row_cell_end = row_cell_ff == CCW'(CHECKER_CELL - 1);

   // classification of the beat being accepted
   assign req_stall   = (state_ff != S_RUN) || q_full;
   assign q_push      = accept;
   assign q_pix       = req_pix;
   assign q_x         = dst_col_ff;
   assign q_row       = 8'(dst_row_ff);
   assign q_ctl.first = col_first_ff && row_first_ff;
   assign q_ctl.emit  = ({1'b0, src_col_in} == col_edge_ff) &&
                        ({1'b0, src_row_in} == row_edge_ff);
   assign q_ctl.last  = (TW'(dst_col_ff) + TW'(1) == tw_ff) &&
                        (TW'(dst_row_ff) + TW'(1) == th_ff);
   assign q_ctl.odd   = col_odd_ff ^ row_odd_ff;
   assign thumb_w     = tw_ff;
   assign thumb_h     = th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         reg_w_ff <= RST_SRC_WIDTH;
         reg_h_ff <= RST_SRC_HEIGHT;
         reg_m_ff <= RST_MAX_DIM;
         start_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         if (csr_hit) begin
            // register write restarts sizing and the frame
            case (csr_index)
               REG_SRC_WIDTH:  reg_w_ff <= csr_wdata;
               REG_SRC_HEIGHT: reg_h_ff <= csr_wdata;
               REG_MAX_DIM:    reg_m_ff <= csr_wdata[8:0];
               default:        reg_m_ff <= reg_m_ff;
            endcase
            state_ff <= S_INIT;
         end else begin
            case (state_ff)
               S_INIT: begin
                  if (fits_m) begin
                     tw_ff    <= TW'(eff_w);
                     th_ff    <= TW'(eff_h);
                     num_ff   <= NW'(eff_w);
                     den_ff   <= DW'(eff_w);
                     state_ff <= S_QW;
                  end else begin
                     num_ff   <= NW'(eff_w) * NW'(eff_m);
                     den_ff   <= DW'(longest);
                     state_ff <= S_TW;
                  end
               end
               S_TW: begin
                  if (got) begin
                     tw_ff    <= fit_side;
                     num_ff   <= NW'(eff_h) * NW'(eff_m);
                     den_ff   <= DW'(longest);
                     state_ff <= S_TH;
                  end
               end
               S_TH: begin
                  if (got) begin
                     th_ff    <= fit_side;
                     num_ff   <= NW'(eff_w);
                     den_ff   <= DW'(tw_ff);
                     state_ff <= S_QW;
                  end
               end
               S_QW: begin
                  if (got) begin
                     qw_ff    <= SW'(div_quo);
                     rw_ff    <= TW'(div_rem);
                     num_ff   <= NW'(eff_h);
                     den_ff   <= DW'(th_ff);
                     state_ff <= S_QH;
                  end
               end
               S_QH: begin
                  if (got) begin
                     qh_ff        <= SW'(div_quo);
                     rh_ff        <= TW'(div_rem);
                     src_col_ff   <= '0;
                     src_row_ff   <= '0;
                     dst_col_ff   <= '0;
                     dst_row_ff   <= '0;
                     col_edge_ff  <= EW'(qw_ff);
                     col_rem_ff   <= rw_ff;
                     row_edge_ff  <= EW'(div_quo);
                     row_rem_ff   <= TW'(div_rem);
                     col_first_ff <= 1'b1;
                     row_first_ff <= 1'b1;
                     col_cell_ff  <= '0;
                     row_cell_ff  <= '0;
                     col_odd_ff   <= 1'b0;
                     row_odd_ff   <= 1'b0;
                     state_ff     <= S_RUN;
                  end
               end
               S_RUN: begin
                  if (accept) begin
                     if (col_wrap) begin
                        // end of a source line
                        src_col_ff   <= '0;
                        dst_col_ff   <= '0;
                        col_edge_ff  <= EW'(qw_ff);
                        col_rem_ff   <= rw_ff;
                        col_first_ff <= 1'b1;
                        col_cell_ff  <= '0;
                        col_odd_ff   <= 1'b0;
                        if (row_wrap) begin
                           src_row_ff   <= '0;
                           dst_row_ff   <= '0;
                           row_edge_ff  <= EW'(qh_ff);
                           row_rem_ff   <= rh_ff;
                           row_first_ff <= 1'b1;
                           row_cell_ff  <= '0;
                           row_odd_ff   <= 1'b0;
                        end else begin
                           src_row_ff <= src_row_in;
                           if (row_hit) begin
                              dst_row_ff   <= dst_row_ff + XW'(1);
                              row_edge_ff  <= row_edge_in;
                              row_rem_ff   <= row_rem_in;
                              row_first_ff <= 1'b1;
                              row_cell_ff  <= row_cell_end ? '0 : row_cell_ff + CCW'(1);
                              row_odd_ff   <= row_odd_ff ^ row_cell_end;
                           end else begin
                              row_first_ff <= 1'b0;
                           end
                        end
                     end else begin
                        src_col_ff <= src_col_in;
                        if (col_hit) begin
                           dst_col_ff   <= dst_col_ff + XW'(1);
                           col_edge_ff  <= col_edge_in;
                           col_rem_ff   <= col_rem_in;
                           col_first_ff <= 1'b1;
                           col_cell_ff  <= col_cell_end ? '0 : col_cell_ff + CCW'(1);
                           col_odd_ff   <= col_odd_ff ^ col_cell_end;
                        end else begin
                           col_first_ff <= 1'b0;
                        end
                     end
                  end
               end
               default: state_ff <= S_INIT;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bdac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// column accumulators, box mean and checkerboard composite
module bdac_back
   import bdac_pkg::*;
#(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_THUMB_DIM = DEF_MAX_THUMB_DIM,
   localparam int SW  = $clog2(MAX_SRC_DIM + 1),
   localparam int TW  = $clog2(MAX_THUMB_DIM + 1),
   localparam int XW  = (MAX_THUMB_DIM > 1) ? $clog2(MAX_THUMB_DIM) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   output logic          q_pop,
   input  pix_type       q_pix,
   input  ctl_type       q_ctl,
   input  logic [XW-1:0] q_x,
   input  logic [7:0]    q_row,
   input  logic [TW-1:0] thumb_w,
   input  logic [TW-1:0] thumb_h,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_red,
   output logic [7:0]    rsp_out_green,
   output logic [7:0]    rsp_out_blue,
   output logic [7:0]    rsp_column,
   output logic [7:0]    rsp_row,
   output logic          rsp_last_pixel,
   output logic [8:0]    rsp_thumb_width,
   output logic [8:0]    rsp_thumb_height
);

   localparam int CW   = 2 * SW;
   localparam int SUMW = CW + 8;
   localparam int ENTW = 4 * SUMW + CW;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ACC,
      B_DIV,
      B_MUL,
      B_FIN
   } state_type;

   state_type state_ff;

   logic [ENTW-1:0] mem [MAX_THUMB_DIM];
   logic [ENTW-1:0] rd_ff;

   pix_type       pix_ff;
   ctl_type       ctl_ff;
   logic [XW-1:0] x_ff;
   logic [7:0]    row_ff;

   logic [SUMW-1:0] lane_ff [4];
   logic [7:0]      quo_ff  [4];
   logic [CW-1:0]   den_ff;
   logic [2:0]      step_ff;
   logic [15:0]     mix_ff  [3];

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [7:0]    red_ff, green_ff, blue_ff, column_ff, row_out_ff;
   logic          last_ff;
   logic [8:0]    width_ff, height_ff;

   logic [ENTW-1:0] base;
   logic [ENTW-1:0] acc_in;
   logic [7:0]      pix_ch [4];
   logic [SUMW-1:0] trial;
   logic [7:0]      bg;
   logic [15:0]     mix_in [3];
   logic [16:0]     scaled [3];
   logic [7:0]      blend  [3];
   logic            wr_en;
   logic            out_free;

   assign pix_ch[0] = pix_ff.red;
   assign pix_ch[1] = pix_ff.green;
   assign pix_ch[2] = pix_ff.blue;
   assign pix_ch[3] = pix_ff.alpha;

   // add the pixel to its column entry, fresh on the first touch of a box
   always_comb begin
      base = ctl_ff.first ? '0 : rd_ff;
      acc_in[CW-1:0] = base[CW-1:0] + CW'(1);
      for (int i = 0; i < 4; i++) begin
         acc_in[CW + i*SUMW +: SUMW] = base[CW + i*SUMW +: SUMW] + SUMW'(pix_ch[i]);
      end
   end

   assign wr_en = (state_ff == B_ACC) && !ctl_ff.emit;
   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   // column memory, registered read
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= mem[q_x];
      end
      if (wr_en) begin
         mem[x_ff] <= acc_in;
      end
   end

   // mean quotient is below 256, so eight shifted trial subtracts
   assign trial = SUMW'(den_ff) << step_ff;

   // c*a + bg*(255-a), then divide by 255 with a shift-add
   assign bg = ctl_ff.odd ? BG_LIGHT : BG_DARK;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mix_in[i] = 16'(quo_ff[i]) * 16'(quo_ff[3]) +
                     16'(bg) * 16'(8'd255 - quo_ff[3]);
         scaled[i] = 17'(mix_ff[i]) + 17'(mix_ff[i] >> 8) + 17'(1);
         blend[i]  = scaled[i][15:8];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // output beat loads from the finish step, holds while stalled
   assign rsp_valid_in = ((state_ff == B_FIN) && out_free) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  pix_ff   <= q_pix;
                  ctl_ff   <= q_ctl;
                  x_ff     <= q_x;
                  row_ff   <= q_row;
                  state_ff <= B_ACC;
               end
            end
            B_ACC: begin
               if (ctl_ff.emit) begin
                  for (int i = 0; i < 4; i++) begin
                     lane_ff[i] <= acc_in[CW + i*SUMW +: SUMW];
                     quo_ff[i]  <= '0;
                  end
                  den_ff   <= acc_in[CW-1:0];
                  step_ff  <= 3'd7;
                  state_ff <= B_DIV;
               end else begin
                  state_ff <= B_IDLE;
               end
            end
            B_DIV: begin
               for (int i = 0; i < 4; i++) begin
                  if (lane_ff[i] >= trial) begin
                     lane_ff[i]         <= lane_ff[i] - trial;
                     quo_ff[i][step_ff] <= 1'b1;
                  end
               end
               step_ff <= step_ff - 3'd1;
               if (step_ff == 3'd0) begin
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               for (int i = 0; i < 3; i++) begin
                  mix_ff[i] <= mix_in[i];
               end
               state_ff <= B_FIN;
            end
            B_FIN: begin
               if (out_free) begin
                  red_ff       <= blend[0];
                  green_ff     <= blend[1];
                  blue_ff      <= blend[2];
                  column_ff    <= 8'(x_ff);
                  row_out_ff   <= row_ff;
                  last_ff      <= ctl_ff.last;
                  width_ff     <= 9'(thumb_w);
                  height_ff    <= 9'(thumb_h);
                  state_ff     <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = red_ff;
   assign rsp_out_green    = green_ff;
   assign rsp_out_blue     = blue_ff;
   assign rsp_column       = column_ff;
   assign rsp_row          = row_out_ff;
   assign rsp_last_pixel   = last_ff;
   assign rsp_thumb_width  = width_ff;
   assign rsp_thumb_height = height_ff;

endmodule

`default_nettype wire

// ===== hdl/box_downscale_alpha_checker_composite.sv =====
// Box-filter thumbnail with alpha composite over a checkerboard.
// Source RGBA pixels enter on the req_ channel in raster order; one rsp_
// beat leaves for each finished box, carrying the composited color, the
// thumbnail coordinates, a frame-end flag and the computed thumbnail size.
// Registers are to be written on the csr_ port only while idle; the block
// does not enforce this. A write to any of the three registers recomputes
// the size and restarts the frame at source pixel (0,0).
// After reset and after each register write the block stalls req_ while a
// serial divider works out the size and box pitches in four divides (two
// when the source fits as is). The front takes one pixel per cycle unless
// sizing runs or its 4-entry queue is full. Per pixel the back does a
// read-modify-write of the column accumulator memory and takes no new pixel
// until done; a box-closing pixel is not written back but goes through an
// 8-step mean divide, blend multiply and output load. A stalled result stays
// in the output register while the back keeps accumulating; the back waits
// only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module box_downscale_alpha_checker_composite
   import bdac_pkg::*;
#(
   parameter int MAX_SRC_DIM   = DEF_MAX_SRC_DIM,
   parameter int MAX_THUMB_DIM = DEF_MAX_THUMB_DIM,
   parameter int CHECKER_CELL  = DEF_CHECKER_CELL
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_alpha,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_column,
   output logic [7:0]             rsp_row,
   output logic                   rsp_last_pixel,
   output logic [8:0]             rsp_thumb_width,
   output logic [8:0]             rsp_thumb_height
);

   localparam int TW  = $clog2(MAX_THUMB_DIM + 1);
   localparam int XW  = (MAX_THUMB_DIM > 1) ? $clog2(MAX_THUMB_DIM) : 1;
   localparam int QDW = $bits(pix_type) + $bits(ctl_type) + XW + 8;

   pix_type       req_pix;
   logic          q_full, q_push, q_pop, q_empty;
   pix_type       f_pix, b_pix;
   ctl_type       f_ctl, b_ctl;
   logic [XW-1:0] f_x, b_x;
   logic [7:0]    f_row, b_row;
   logic [QDW-1:0] q_din, q_dout;
   logic [TW-1:0] thumb_w, thumb_h;

   assign req_pix.red   = req_red;
   assign req_pix.green = req_green;
   assign req_pix.blue  = req_blue;
   assign req_pix.alpha = req_alpha;

   bdac_front #(
      .MAX_SRC_DIM   (MAX_SRC_DIM),
      .MAX_THUMB_DIM (MAX_THUMB_DIM),
      .CHECKER_CELL  (CHECKER_CELL)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pix      (req_pix),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_pix        (f_pix),
      .q_ctl        (f_ctl),
      .q_x          (f_x),
      .q_row        (f_row),
      .thumb_w      (thumb_w),
      .thumb_h      (thumb_h)
   );

   // queue beat packing
   assign q_din = {f_pix, f_ctl, f_x, f_row};
   assign {b_pix, b_ctl, b_x, b_row} = q_dout;

   bdac_fifo #(
      .WIDTH (QDW)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   bdac_back #(
      .MAX_SRC_DIM   (MAX_SRC_DIM),
      .MAX_THUMB_DIM (MAX_THUMB_DIM)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .q_pix            (b_pix),
      .q_ctl            (b_ctl),
      .q_x              (b_x),
      .q_row            (b_row),
      .thumb_w          (thumb_w),
      .thumb_h          (thumb_h),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_red      (rsp_out_red),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_thumb_width  (rsp_thumb_width),
      .rsp_thumb_height (rsp_thumb_height)
   );

endmodule

`default_nettype wire
